// ----- hdl/tds_pkg.sv -----
// ----------------------------------------------------------------------------
// tds_pkg
// Shared widths, request and status codes, and controller/datapath links.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tds_pkg;

  localparam int REQ_W    = 3;
  localparam int SLOT_W   = 5;
  localparam int IDENT_W  = 10;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;
  localparam int LIST_W   = 5;

  localparam int RESULT_CAP = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD_TASK = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ADD_DEP  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_START    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_COMPLETE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_LIST     = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DEP_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY_SLOT = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NONE_READY = 3'd4;

  typedef enum logic [2:0] {
    RSP_OK         = 3'd0,
    RSP_TABLE_FULL = 3'd1,
    RSP_ADD_OK     = 3'd2,
    RSP_DEP_FULL   = 3'd3,
    RSP_EMPTY_SLOT = 3'd4,
    RSP_NONE_READY = 3'd5,
    RSP_LIST_ITEM  = 3'd6
  } rsp_kind_t;

  typedef struct packed {
    logic      take_req;
    logic      clr_all;
    logic      add_task;
    logic      start_all;
    logic      scan_rst;
    logic      slot_inc;
    logic      mark_found;
    logic      dep_rst;
    logic      dep_inc;
    logic      cnt_upd;
    logic      dep_add;
    logic      emit;
    rsp_kind_t rsp;
  } tds_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             out_free;
    logic             full;
    logic             slot_ok;
    logic             used_zero;
    logic             any_ready;
    logic             dep_full;
    logic             id_match;
    logic             total_zero;
    logic             last_slot;
    logic             dep_match;
    logic             last_dep;
    logic             cur_ready;
    logic             list_last;
  } tds_sts_t;

endpackage

// ----- hdl/tds_if.sv -----
// ----------------------------------------------------------------------------
// tds_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tds_in_if import tds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [SLOT_W-1:0]  task_slot;
  logic [IDENT_W-1:0] task_ident;
  logic [IDENT_W-1:0] dependency_ident;

  modport source (output valid, req_type, task_slot, task_ident, dependency_ident,
                  input ready);
  modport sink   (input valid, req_type, task_slot, task_ident, dependency_ident,
                  output ready);
endinterface

interface tds_out_if import tds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDENT_W-1:0]  ready_ident;
  logic [SLOT_W-1:0]   ready_slot;
  logic                last;

  modport source (output valid, status, ready_ident, ready_slot, last,
                  input ready);
  modport sink   (input valid, status, ready_ident, ready_slot, last,
                  output ready);
endinterface

// ----- hdl/task_dependency_scoreboard.sv -----
// ----------------------------------------------------------------------------
// task_dependency_scoreboard
// Clear, add task and start are answered from the decode state. Add dependency
// answers from a check state after the slot is read. Complete scans every used
// slot, reading its identifier and, where needed, its dependency entries from the
// registered-read table RAMs. List scans the slots, one result per ready slot.
// One request at a time; the next is taken after the last result is loaded.
// Synchronous reset empties the table; RAM contents are kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module task_dependency_scoreboard import tds_pkg::*; #(
  parameter int MAX_TASKS = 32,
  parameter int MAX_DEPS  = 8,
  parameter int ID_BITS   = 10
) (
  input logic        clk,
  input logic        rst_n,
  tds_in_if.sink     in_chan,
  tds_out_if.source  out_chan
);

  tds_cmd_t cmd;
  tds_sts_t sts;
  logic     in_ready;

  assign in_chan.ready = in_ready;

  tds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tds_dpath #(
    .MAX_TASKS (MAX_TASKS),
    .MAX_DEPS  (MAX_DEPS),
    .ID_BITS   (ID_BITS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_req_type         (in_chan.req_type),
    .in_task_slot        (in_chan.task_slot),
    .in_task_ident       (in_chan.task_ident),
    .in_dependency_ident (in_chan.dependency_ident),
    .out_valid           (out_chan.valid),
    .out_ready           (out_chan.ready),
    .out_status          (out_chan.status),
    .out_ready_ident     (out_chan.ready_ident),
    .out_ready_slot      (out_chan.ready_slot),
    .out_last            (out_chan.last)
  );

endmodule

// ----- hdl/tds_ram.sv -----
// ----------------------------------------------------------------------------
// tds_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/tds_ctrl.sv -----
// ----------------------------------------------------------------------------
// tds_ctrl
// Request sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tds_ctrl import tds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tds_sts_t sts,
  output tds_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'h001,
    S_DECODE    = 10'h002,
    S_ADEP_CHK  = 10'h004,
    S_SLOT_RD   = 10'h008,
    S_SLOT_CHK  = 10'h010,
    S_DEP_RD    = 10'h020,
    S_DEP_CHK   = 10'h040,
    S_FIN       = 10'h080,
    S_LIST_SCAN = 10'h100,
    S_LIST_EMIT = 10'h200
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rsp   = RSP_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_req = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req_type)
          REQ_CLEAR: begin
            if (sts.out_free) begin
              cmd.clr_all = 1'b1;
              cmd.emit    = 1'b1;
              state_nxt   = S_IDLE;
            end
          end
          REQ_ADD_TASK: begin
            if (sts.out_free) begin
              cmd.emit = 1'b1;
              if (sts.full) begin
                cmd.rsp = RSP_TABLE_FULL;
              end else begin
                cmd.add_task = 1'b1;
                cmd.rsp      = RSP_ADD_OK;
              end
              state_nxt = S_IDLE;
            end
          end
          REQ_ADD_DEP: begin
            if (sts.slot_ok) begin
              state_nxt = S_ADEP_CHK;
            end else if (sts.out_free) begin
              cmd.emit  = 1'b1;
              cmd.rsp   = RSP_EMPTY_SLOT;
              state_nxt = S_IDLE;
            end
          end
          REQ_START: begin
            if (sts.out_free) begin
              cmd.start_all = 1'b1;
              cmd.emit      = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          REQ_COMPLETE: begin
            cmd.scan_rst = 1'b1;
            state_nxt    = sts.used_zero ? S_FIN : S_SLOT_RD;
          end
          REQ_LIST: begin
            if (sts.any_ready) begin
              cmd.scan_rst = 1'b1;
              state_nxt    = S_LIST_SCAN;
            end else if (sts.out_free) begin
              cmd.emit  = 1'b1;
              cmd.rsp   = RSP_NONE_READY;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_ADEP_CHK: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.dep_full) begin
            cmd.rsp = RSP_DEP_FULL;
          end else begin
            cmd.dep_add = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_SLOT_RD: begin
        state_nxt = S_SLOT_CHK;
      end
      S_SLOT_CHK: begin
        if (!sts.id_match && !sts.total_zero) begin
          cmd.dep_rst = 1'b1;
          state_nxt   = S_DEP_RD;
        end else begin
          cmd.mark_found = sts.id_match;
          if (sts.last_slot) begin
            state_nxt = S_FIN;
          end else begin
            cmd.slot_inc = 1'b1;
            state_nxt    = S_SLOT_RD;
          end
        end
      end
      S_DEP_RD: begin
        state_nxt = S_DEP_CHK;
      end
      S_DEP_CHK: begin
        if (!sts.dep_match && !sts.last_dep) begin
          cmd.dep_inc = 1'b1;
          state_nxt   = S_DEP_RD;
        end else begin
          cmd.cnt_upd = sts.dep_match;
          if (sts.last_slot) begin
            state_nxt = S_FIN;
          end else begin
            cmd.slot_inc = 1'b1;
            state_nxt    = S_SLOT_RD;
          end
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LIST_SCAN: begin
        if (sts.cur_ready) begin
          state_nxt = S_LIST_EMIT;
        end else begin
          cmd.slot_inc = 1'b1;
        end
      end
      S_LIST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.rsp  = RSP_LIST_ITEM;
          if (sts.list_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.slot_inc = 1'b1;
            state_nxt    = S_LIST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/tds_dpath.sv -----
// ----------------------------------------------------------------------------
// tds_dpath
// Task table storage, scan counters, compares and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tds_dpath import tds_pkg::*; #(
  parameter int MAX_TASKS = 32,
  parameter int MAX_DEPS  = 8,
  parameter int ID_BITS   = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tds_cmd_t            cmd,
  output tds_sts_t            sts,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [SLOT_W-1:0]   in_task_slot,
  input  logic [IDENT_W-1:0]  in_task_ident,
  input  logic [IDENT_W-1:0]  in_dependency_ident,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [IDENT_W-1:0]  out_ready_ident,
  output logic [SLOT_W-1:0]   out_ready_slot,
  output logic                out_last
);

  localparam int SW    = $clog2(MAX_TASKS);
  localparam int CW    = $clog2(MAX_TASKS + 1);
  localparam int DTW   = $clog2(MAX_DEPS + 1);
  localparam int DW    = (MAX_DEPS > 1) ? $clog2(MAX_DEPS) : 1;
  localparam int DEP_DEPTH = MAX_TASKS << DW;

  logic [REQ_W-1:0]   req_type_r;
  logic [SLOT_W-1:0]  req_slot_r;
  logic [ID_BITS-1:0] tid_r;
  logic [ID_BITS-1:0] did_r;

  logic [CW-1:0]        used_r, used_nxt;
  logic [MAX_TASKS-1:0] ready_r, ready_nxt;
  logic [MAX_TASKS-1:0] has_dep_r, has_dep_nxt;
  logic [MAX_TASKS-1:0] tot_vld_r, tot_vld_nxt;
  logic [MAX_TASKS-1:0] cnt_vld_r, cnt_vld_nxt;
  logic [MAX_TASKS-1:0] used_mask;

  logic [SW-1:0]     s_r, s_nxt;
  logic [DTW-1:0]    d_r, d_nxt;
  logic [LIST_W-1:0] n_r, n_nxt;
  logic              found_r, found_nxt;
  logic [SW-1:0]     slot_q_r;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [IDENT_W-1:0]  out_ident_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_last_r;

  logic [SW-1:0]      slot_addr;
  logic [SW-1:0]      new_slot;
  logic [ID_BITS-1:0] id_q;
  logic [ID_BITS-1:0] dep_q;
  logic [DTW-1:0]     tot_rd;
  logic [DTW-1:0]     tot_q;
  logic [COUNT_W-1:0] cnt_rd;
  logic [COUNT_W-1:0] cnt_q;
  logic [COUNT_W-1:0] cnt_new;
  logic               more_ready;
  logic               list_last;

  assign slot_addr = (req_type_r == REQ_ADD_DEP) ? SW'(req_slot_r) : s_r;
  assign new_slot  = SW'(used_r);

  tds_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_TASKS)) u_ident_ram (
    .clk   (clk),
    .we    (cmd.add_task),
    .waddr (new_slot),
    .wdata (tid_r),
    .raddr (slot_addr),
    .rdata (id_q)
  );

  tds_ram #(.WIDTH(DTW), .DEPTH(MAX_TASKS)) u_total_ram (
    .clk   (clk),
    .we    (cmd.dep_add),
    .waddr (slot_addr),
    .wdata (tot_q + DTW'(1)),
    .raddr (slot_addr),
    .rdata (tot_rd)
  );

  tds_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_TASKS)) u_count_ram (
    .clk   (clk),
    .we    (cmd.cnt_upd),
    .waddr (s_r),
    .wdata (cnt_new),
    .raddr (slot_addr),
    .rdata (cnt_rd)
  );

  tds_ram #(.WIDTH(ID_BITS), .DEPTH(DEP_DEPTH)) u_dep_ram (
    .clk   (clk),
    .we    (cmd.dep_add),
    .waddr ({slot_addr, tot_q[DW-1:0]}),
    .wdata (did_r),
    .raddr ({s_r, d_r[DW-1:0]}),
    .rdata (dep_q)
  );

  assign tot_q   = tot_vld_r[slot_q_r] ? tot_rd : '0;
  assign cnt_q   = cnt_vld_r[slot_q_r] ? cnt_rd : '0;
  assign cnt_new = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      used_mask[i] = (CW'(i) < used_r);
    end
  end

  assign more_ready = |((ready_r >> s_r) >> 1);
  assign list_last  = !more_ready || (n_r == LIST_W'(RESULT_CAP - 1));

  always_comb begin
    sts            = '0;
    sts.req_type   = req_type_r;
    sts.out_free   = !out_valid_r || out_ready;
    sts.full       = (used_r == CW'(MAX_TASKS));
    sts.slot_ok    = (32'(req_slot_r) < 32'(used_r));
    sts.used_zero  = (used_r == '0);
    sts.any_ready  = |ready_r;
    sts.dep_full   = (tot_q >= DTW'(MAX_DEPS));
    sts.id_match   = (id_q == tid_r);
    sts.total_zero = (tot_q == '0);
    sts.last_slot  = ((CW'(s_r) + CW'(1)) == used_r);
    sts.dep_match  = (dep_q == tid_r);
    sts.last_dep   = ((d_r + DTW'(1)) == tot_q);
    sts.cur_ready  = ready_r[s_r];
    sts.list_last  = list_last;
  end

  always_comb begin
    used_nxt    = used_r;
    ready_nxt   = ready_r;
    has_dep_nxt = has_dep_r;
    tot_vld_nxt = tot_vld_r;
    cnt_vld_nxt = cnt_vld_r;
    if (cmd.clr_all) begin
      used_nxt    = '0;
      ready_nxt   = '0;
      has_dep_nxt = '0;
      tot_vld_nxt = '0;
      cnt_vld_nxt = '0;
    end
    if (cmd.add_task) begin
      used_nxt              = used_r + CW'(1);
      ready_nxt[new_slot]   = 1'b0;
      has_dep_nxt[new_slot] = 1'b0;
      tot_vld_nxt[new_slot] = 1'b0;
      cnt_vld_nxt[new_slot] = 1'b0;
    end
    if (cmd.start_all) begin
      ready_nxt   = ~has_dep_r & used_mask;
      cnt_vld_nxt = '0;
    end
    if (cmd.dep_add) begin
      has_dep_nxt[slot_addr] = 1'b1;
      tot_vld_nxt[slot_addr] = 1'b1;
    end
    if (cmd.mark_found && !found_r) begin
      ready_nxt[s_r] = 1'b0;
    end
    if (cmd.cnt_upd) begin
      cnt_vld_nxt[s_r] = 1'b1;
      if (cnt_new >= COUNT_W'(tot_q)) begin
        ready_nxt[s_r] = 1'b1;
      end
    end
  end

  always_comb begin
    s_nxt     = s_r;
    d_nxt     = d_r;
    n_nxt     = n_r;
    found_nxt = found_r;
    if (cmd.scan_rst) begin
      s_nxt     = '0;
      n_nxt     = '0;
      found_nxt = 1'b0;
    end
    if (cmd.slot_inc) begin
      s_nxt = s_r + SW'(1);
    end
    if (cmd.dep_rst) begin
      d_nxt = '0;
    end
    if (cmd.dep_inc) begin
      d_nxt = d_r + DTW'(1);
    end
    if (cmd.mark_found) begin
      found_nxt = 1'b1;
    end
    if (cmd.emit && (cmd.rsp == RSP_LIST_ITEM)) begin
      n_nxt = n_r + LIST_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      ready_r     <= '0;
      has_dep_r   <= '0;
      tot_vld_r   <= '0;
      cnt_vld_r   <= '0;
      s_r         <= '0;
      d_r         <= '0;
      n_r         <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      ready_r     <= ready_nxt;
      has_dep_r   <= has_dep_nxt;
      tot_vld_r   <= tot_vld_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      s_r         <= s_nxt;
      d_r         <= d_nxt;
      n_r         <= n_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_q_r <= slot_addr;
    if (cmd.take_req) begin
      req_type_r <= in_req_type;
      req_slot_r <= in_task_slot;
      tid_r      <= ID_BITS'(in_task_ident);
      did_r      <= ID_BITS'(in_dependency_ident);
    end
    if (cmd.emit) begin
      out_status_r <= STAT_OK;
      out_ident_r  <= '0;
      out_slot_r   <= '0;
      out_last_r   <= 1'b1;
      case (cmd.rsp)
        RSP_TABLE_FULL: out_status_r <= STAT_TABLE_FULL;
        RSP_DEP_FULL:   out_status_r <= STAT_DEP_FULL;
        RSP_EMPTY_SLOT: out_status_r <= STAT_EMPTY_SLOT;
        RSP_NONE_READY: out_status_r <= STAT_NONE_READY;
        RSP_ADD_OK: begin
          out_ident_r <= IDENT_W'(tid_r);
          out_slot_r  <= SLOT_W'(used_r);
        end
        RSP_LIST_ITEM: begin
          out_ident_r <= IDENT_W'(id_q);
          out_slot_r  <= SLOT_W'(s_r);
          out_last_r  <= list_last;
        end
        default: out_status_r <= STAT_OK;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_ready_ident = out_ident_r;
  assign out_ready_slot  = out_slot_r;
  assign out_last        = out_last_r;

endmodule

// ----- tb/tds_checker.sv -----
// ----------------------------------------------------------------------------
// tds_checker
// Watches the request and result channels of the task dependency scoreboard,
// keeps its own copy of the task table, works out the results of every
// accepted request and compares each accepted result with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tds_checker import tds_pkg::*; #(
  parameter int MAX_TASKS = 32,
  parameter int MAX_DEPS  = 8,
  parameter int ID_BITS   = 10
) (
  input  logic clk,
  input  logic rst_n,
  tds_in_if    in_mon,
  tds_out_if   out_mon,
  output int   error_count,
  output int   expected_left,
  output int   results_checked
);

  localparam logic [IDENT_W-1:0] ID_MASK = IDENT_W'((1 << ID_BITS) - 1);

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [IDENT_W-1:0]  ident;
    logic [SLOT_W-1:0]   slot;
    logic                last;
  } sched_result_t;

  sched_result_t due_results[$];

  logic [IDENT_W-1:0] task_id_tab [MAX_TASKS];
  logic [IDENT_W-1:0] dep_tab     [MAX_TASKS][MAX_DEPS];
  logic [3:0]         dep_cnt     [MAX_TASKS];
  logic [COUNT_W-1:0] done_tab    [MAX_TASKS];
  logic               ready_tab   [MAX_TASKS];
  int                 filled;

  function automatic void push_result(logic [STATUS_W-1:0] status,
                                      logic [IDENT_W-1:0] ident,
                                      logic [SLOT_W-1:0] slot, logic last);
    sched_result_t r;
    r.status = status;
    r.ident  = ident;
    r.slot   = slot;
    r.last   = last;
    due_results.push_back(r);
  endfunction

  function automatic void empty_table();
    int s;
    for (s = 0; s < MAX_TASKS; s++) begin
      dep_cnt[s]   = '0;
      done_tab[s]  = '0;
      ready_tab[s] = 1'b0;
    end
    filled = 0;
  endfunction

  function automatic void retire_task(logic [IDENT_W-1:0] id);
    int  s, d;
    bit  found, hit;
    found = 0;
    for (s = 0; s < filled; s++) begin
      if (!found && task_id_tab[s] == id) begin
        ready_tab[s] = 1'b0;
        found = 1;
      end
    end
    for (s = 0; s < filled; s++) begin
      hit = 0;
      if (task_id_tab[s] != id) begin
        for (d = 0; d < int'(dep_cnt[s]); d++)
          if (dep_tab[s][d] == id) hit = 1;
      end
      if (hit) begin
        if (done_tab[s] != COUNT_MAX) done_tab[s] = done_tab[s] + 1'b1;
        if (done_tab[s] >= COUNT_W'(dep_cnt[s])) ready_tab[s] = 1'b1;
      end
    end
  endfunction

  function automatic void schedule_request(logic [REQ_W-1:0] req, logic [SLOT_W-1:0] slot,
                                           logic [IDENT_W-1:0] tid,
                                           logic [IDENT_W-1:0] did);
    int s, n, k;
    case (req)
      REQ_CLEAR: begin
        empty_table();
        push_result(STAT_OK, '0, '0, 1'b1);
      end
      REQ_ADD_TASK: begin
        if (filled >= MAX_TASKS) begin
          push_result(STAT_TABLE_FULL, '0, '0, 1'b1);
        end else begin
          task_id_tab[filled] = tid;
          dep_cnt[filled]     = '0;
          done_tab[filled]    = '0;
          ready_tab[filled]   = 1'b0;
          push_result(STAT_OK, tid, SLOT_W'(filled), 1'b1);
          filled++;
        end
      end
      REQ_ADD_DEP: begin
        if (int'(slot) >= filled) begin
          push_result(STAT_EMPTY_SLOT, '0, '0, 1'b1);
        end else if (int'(dep_cnt[slot]) >= MAX_DEPS) begin
          push_result(STAT_DEP_FULL, '0, '0, 1'b1);
        end else begin
          dep_tab[slot][dep_cnt[slot]] = did;
          dep_cnt[slot] = dep_cnt[slot] + 1'b1;
          push_result(STAT_OK, '0, '0, 1'b1);
        end
      end
      REQ_START: begin
        for (s = 0; s < filled; s++) begin
          ready_tab[s] = (dep_cnt[s] == '0);
          done_tab[s]  = '0;
        end
        push_result(STAT_OK, '0, '0, 1'b1);
      end
      REQ_COMPLETE: begin
        retire_task(tid);
        push_result(STAT_OK, '0, '0, 1'b1);
      end
      REQ_LIST: begin
        n = 0;
        for (s = 0; s < filled; s++)
          if (ready_tab[s] && n < RESULT_CAP) n++;
        if (n == 0) begin
          push_result(STAT_NONE_READY, '0, '0, 1'b1);
        end else begin
          k = 0;
          for (s = 0; s < filled; s++) begin
            if (ready_tab[s] && k < n) begin
              push_result(STAT_OK, task_id_tab[s], SLOT_W'(s), k == n - 1);
              k++;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void match_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_result();
    sched_result_t want;
    if (due_results.size() == 0) begin
      $error("result with nothing due: status %0d ready_ident %0d ready_slot %0d last %0d",
             out_mon.status, out_mon.ready_ident, out_mon.ready_slot, out_mon.last);
      error_count++;
    end else begin
      want = due_results.pop_front();
      match_field("status", 16'(want.status), 16'(out_mon.status));
      match_field("ready_ident", 16'(want.ident), 16'(out_mon.ready_ident));
      match_field("ready_slot", 16'(want.slot), 16'(out_mon.ready_slot));
      match_field("last", 16'(want.last), 16'(out_mon.last));
    end
    results_checked++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      empty_table();
      due_results.delete();
      error_count     = 0;
      results_checked = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready)
        schedule_request(in_mon.req_type, in_mon.task_slot,
                         in_mon.task_ident & ID_MASK, in_mon.dependency_ident & ID_MASK);
    end
    expected_left <= due_results.size();
  end

endmodule

// ----- tb/tb_task_dependency_scoreboard.sv -----
// ----------------------------------------------------------------------------
// tb_task_dependency_scoreboard
// Drives the task dependency scoreboard with directed requests, a full table,
// a completion count pushed to saturation and random dependency graphs mixed
// with noise, under changing idle and stall patterns; the checker judges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_task_dependency_scoreboard;
  import tds_pkg::*;

  localparam int MAX_TASKS     = 32;
  localparam int MAX_DEPS      = 8;
  localparam int ID_BITS       = 10;
  localparam int RANDOM_ITEMS  = 150;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 2 + MAX_TASKS * (2 + 2 * MAX_DEPS) + 32;

  localparam logic [REQ_W-1:0]   REQ_BAD_LO = 3'd6;
  localparam logic [REQ_W-1:0]   REQ_BAD_HI = 3'd7;
  localparam logic [SLOT_W-1:0]  SLOT_TOP   = '1;
  localparam logic [IDENT_W-1:0] IDENT_TOP  = '1;

  logic clk;
  logic rst_n;

  tds_in_if  in_chan ();
  tds_out_if out_chan ();

  int error_count, expected_left, results_checked;
  int send_idle_pct, stall_pct, hold_tokens;
  int sent_total, random_sent, cycle_count;
  bit counting;

  task_dependency_scoreboard #(
    .MAX_TASKS (MAX_TASKS),
    .MAX_DEPS  (MAX_DEPS),
    .ID_BITS   (ID_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  tds_checker #(
    .MAX_TASKS (MAX_TASKS),
    .MAX_DEPS  (MAX_DEPS),
    .ID_BITS   (ID_BITS)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .error_count     (error_count),
    .expected_left   (expected_left),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results still due",
             cycle_count, expected_left);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int hold_seen, hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tokens != hold_seen) begin
        hold_seen = hold_tokens;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_request(logic [REQ_W-1:0] req, logic [SLOT_W-1:0] slot,
                              logic [IDENT_W-1:0] tid, logic [IDENT_W-1:0] did);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid            <= 1'b1;
    in_chan.req_type         <= req;
    in_chan.task_slot        <= slot;
    in_chan.task_ident       <= tid;
    in_chan.dependency_ident <= did;
    do @(posedge clk); while (!in_chan.ready);
    sent_total++;
    if (counting && req <= REQ_LIST) random_sent++;
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
  endtask

  task automatic run_directed();
    send_request(REQ_LIST, SLOT_TOP, IDENT_TOP, IDENT_TOP);
    send_request(REQ_START, '0, '0, '0);
    send_request(REQ_COMPLETE, '0, '0, '0);
    send_request(REQ_ADD_DEP, '0, '0, '0);
    send_request(REQ_ADD_TASK, SLOT_TOP, '0, IDENT_TOP);
    send_request(REQ_ADD_TASK, '0, IDENT_TOP, '0);
    send_request(REQ_ADD_TASK, '0, 10'd5, '0);
    send_request(REQ_ADD_TASK, '0, 10'd5, '0);
    send_request(REQ_ADD_DEP, 5'd1, '0, '0);
    send_request(REQ_ADD_DEP, SLOT_TOP, '0, '0);
    send_request(REQ_ADD_DEP, 5'd2, '0, IDENT_TOP);
    send_request(REQ_ADD_DEP, 5'd3, '0, IDENT_TOP);
    send_request(REQ_BAD_LO, SLOT_TOP, IDENT_TOP, IDENT_TOP);
    send_request(REQ_BAD_HI, SLOT_TOP, IDENT_TOP, IDENT_TOP);
    send_request(REQ_START, '0, '0, '0);
    send_request(REQ_LIST, '0, '0, '0);
    send_request(REQ_COMPLETE, '0, '0, '0);
    send_request(REQ_COMPLETE, '0, IDENT_TOP, '0);
    send_request(REQ_LIST, '0, '0, '0);
    // duplicate identifier: only the first slot drops its flag
    send_request(REQ_COMPLETE, '0, 10'd5, '0);
    send_request(REQ_LIST, '0, '0, '0);
    send_request(REQ_CLEAR, SLOT_TOP, IDENT_TOP, IDENT_TOP);
    send_request(REQ_LIST, '0, '0, '0);
  endtask

  task automatic run_full_table();
    int i;
    send_request(REQ_CLEAR, '0, '0, '0);
    for (i = 0; i <= MAX_TASKS; i++)
      send_request(REQ_ADD_TASK, SLOT_W'($urandom), IDENT_W'(i * 29 + 3), IDENT_W'($urandom));
    send_request(REQ_START, '0, '0, '0);
    send_request(REQ_LIST, '0, '0, '0);
    for (i = 0; i <= MAX_DEPS; i++)
      send_request(REQ_ADD_DEP, SLOT_W'(MAX_TASKS - 1), IDENT_W'($urandom),
                   IDENT_W'(i * 29 + 3));
    send_request(REQ_START, '0, '0, '0);
    for (i = 0; i < MAX_DEPS; i++)
      send_request(REQ_COMPLETE, SLOT_W'($urandom), IDENT_W'(i * 29 + 3), IDENT_W'($urandom));
    send_request(REQ_LIST, '0, '0, '0);
  endtask

  task automatic run_saturation();
    send_request(REQ_CLEAR, '0, '0, '0);
    send_request(REQ_ADD_TASK, '0, 10'd7, '0);
    send_request(REQ_ADD_TASK, '0, 10'd9, '0);
    send_request(REQ_ADD_DEP, 5'd1, '0, 10'd7);
    send_request(REQ_START, '0, '0, '0);
    repeat (int'(COUNT_MAX)) send_request(REQ_COMPLETE, '0, 10'd7, '0);
    // drop the flag, then one more count at saturation must set the task ready again
    send_request(REQ_COMPLETE, '0, 10'd9, '0);
    send_request(REQ_COMPLETE, '0, 10'd7, '0);
    send_request(REQ_LIST, '0, '0, '0);
  endtask

  task automatic run_graph();
    logic [IDENT_W-1:0] ids[$];
    logic [IDENT_W-1:0] id;
    logic [SLOT_W-1:0]  slot;
    int n_tasks, span, n_links, n_steps, i;
    bit focus;
    n_tasks = ($urandom_range(7) == 0) ? $urandom_range(MAX_TASKS + 1, 12)
                                       : $urandom_range(6, 1);
    span  = (n_tasks < MAX_TASKS) ? n_tasks : MAX_TASKS;
    focus = ($urandom_range(3) == 0);
    send_request(REQ_CLEAR, SLOT_W'($urandom), IDENT_W'($urandom), IDENT_W'($urandom));
    for (i = 0; i < n_tasks; i++) begin
      if (i > 0 && $urandom_range(4) == 0) id = ids[$urandom_range(ids.size() - 1)];
      else id = IDENT_W'($urandom);
      ids.push_back(id);
      send_request(REQ_ADD_TASK, SLOT_W'($urandom), id, IDENT_W'($urandom));
    end
    n_links = focus ? $urandom_range(MAX_DEPS + 2, MAX_DEPS - 2)
                    : $urandom_range(2 * n_tasks + 2);
    for (i = 0; i < n_links; i++) begin
      if ($urandom_range(9) == 0) slot = SLOT_W'($urandom);
      else if (focus) slot = '0;
      else slot = SLOT_W'($urandom_range(span - 1));
      if ($urandom_range(5) == 0) id = IDENT_W'($urandom);
      else id = ids[$urandom_range(ids.size() - 1)];
      send_request(REQ_ADD_DEP, slot, IDENT_W'($urandom), id);
    end
    send_request(REQ_START, SLOT_W'($urandom), IDENT_W'($urandom), IDENT_W'($urandom));
    n_steps = $urandom_range(n_tasks + 3, 1);
    for (i = 0; i < n_steps; i++) begin
      if ($urandom_range(3) == 0) begin
        send_request(REQ_LIST, SLOT_W'($urandom), IDENT_W'($urandom), IDENT_W'($urandom));
      end else begin
        if ($urandom_range(6) == 0) id = IDENT_W'($urandom);
        else id = ids[$urandom_range(ids.size() - 1)];
        send_request(REQ_COMPLETE, SLOT_W'($urandom), id, IDENT_W'($urandom));
      end
    end
    send_request(REQ_LIST, SLOT_W'($urandom), IDENT_W'($urandom), IDENT_W'($urandom));
  endtask

  initial begin
    int phase;
    bit hold_done;
    rst_n                    <= 1'b0;
    in_chan.valid            <= 1'b0;
    in_chan.req_type         <= '0;
    in_chan.task_slot        <= '0;
    in_chan.task_ident       <= '0;
    in_chan.dependency_ident <= '0;
    send_idle_pct = 0;
    stall_pct     <= 0;
    hold_tokens   <= 0;
    sent_total    = 0;
    random_sent   = 0;
    counting      = 0;
    hold_done     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_drained();
    run_full_table();
    wait_drained();
    run_saturation();
    wait_drained();

    counting = 1;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 52; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 52; end
        default: begin send_idle_pct = 13; stall_pct <= 13; end
      endcase
      while (random_sent < (phase + 1) * RANDOM_ITEMS / 4) begin
        if (!hold_done && random_sent >= 10) begin
          hold_tokens <= hold_tokens + 1;
          hold_done = 1;
        end
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(3, 1))
            send_request(REQ_W'($urandom), SLOT_W'($urandom), IDENT_W'($urandom),
                         IDENT_W'($urandom));
        end else begin
          run_graph();
        end
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d random) and checked %0d results in %0d cycles",
             sent_total, random_sent, results_checked, cycle_count);
    $display("Covered full table and lists, dependency overflow, duplicates, saturation");
    if (error_count == 0 && expected_left == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
